### design/rcds_pkg.sv
// Package for the radix conversion digit stack.
// Holds sizes, the controller/datapath command and status structs.
// No dependencies.
package rcds_pkg;

   localparam int MAX_DIGITS = 32;
   localparam int VALUE_W    = 31;
   localparam int BASE_W     = 8;
   localparam int DIGIT_W    = 8;
   localparam int ADDR_W     = $clog2(MAX_DIGITS);
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int STEP_W     = $clog2(VALUE_W);

   localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);

   typedef struct packed {
      logic load;        // take a new request
      logic start;       // clear remainder and step counter
      logic step;        // one restoring division step
      logic push;        // push remainder onto the stack
      logic pop;         // pop top of stack into read register
      logic emit_digit;  // load output register with popped digit
      logic emit_error;  // load output register with the bad base result
   } rcds_cmd_type;

   typedef struct packed {
      logic base_bad;
      logic div_last;
      logic quot_zero;
      logic count_zero;
      logic out_free;
   } rcds_sts_type;

endpackage

### design/rcds_ctrl.sv
// Controller state machine for the radix conversion digit stack.
// Sequences load, division, push, pop and emit. Depends on rcds_pkg.
module rcds_ctrl
   import rcds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rcds_sts_type sts,
   output rcds_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_PUSH  = 3'd3;
   localparam logic [2:0] S_POP   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;
   localparam logic [2:0] S_ERR   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.base_bad) begin
               state_in = S_ERR;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_last) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            if (sts.quot_zero) begin
               state_in = S_POP;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in = sts.count_zero ? S_IDLE : S_POP;
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.emit_error = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### design/rcds_dpath.sv
// Datapath for the radix conversion digit stack: bit-serial divider,
// digit stack memory and output register. Depends on rcds_pkg.
module rcds_dpath
   import rcds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [BASE_W-1:0]   req_base,
   input  rcds_cmd_type        cmd,
   output rcds_sts_type        sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DIGIT_W-1:0]  rsp_digit,
   output logic                rsp_last,
   output logic                rsp_bad_base
);

   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [BASE_W-1:0]  base_ff;
   logic [BASE_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_dec;
   logic [DIGIT_W-1:0] rd_ff;
   logic [DIGIT_W-1:0] stack_mem [MAX_DIGITS];

   logic               valid_ff, valid_in;
   logic [DIGIT_W-1:0] digit_ff;
   logic               last_ff;
   logic               bad_ff;

   logic [BASE_W:0]    trial;
   logic [BASE_W:0]    diff;
   logic               fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quot_ff[VALUE_W-1]};
   assign diff  = trial - {1'b0, base_ff};
   assign fits  = (trial >= {1'b0, base_ff});

   assign count_dec = count_ff - COUNT_W'(1);

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      count_in = count_ff;
      if (cmd.load) begin
         quot_in  = req_value;
         count_in = '0;
      end
      if (cmd.start) begin
         rem_in  = '0;
         step_in = '0;
      end else if (cmd.step) begin
         quot_in = {quot_ff[VALUE_W-2:0], fits};
         rem_in  = fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
         step_in = step_ff + STEP_W'(1);
      end
      if (cmd.push && (count_ff < COUNT_W'(MAX_DIGITS))) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff  <= '0;
         count_ff <= '0;
         rem_ff   <= '0;
         step_ff  <= '0;
      end else begin
         quot_ff  <= quot_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= req_base;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && (count_ff < COUNT_W'(MAX_DIGITS))) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_ff <= stack_mem[count_dec[ADDR_W-1:0]];
      end
   end

   // output register
   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit_digit || cmd.emit_error) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_digit) begin
         digit_ff <= rd_ff;
         last_ff  <= (count_ff == '0);
         bad_ff   <= 1'b0;
      end else if (cmd.emit_error) begin
         digit_ff <= '0;
         last_ff  <= 1'b1;
         bad_ff   <= 1'b1;
      end
   end

   assign sts.base_bad   = (base_ff < MIN_BASE);
   assign sts.div_last   = (step_ff == STEP_W'(VALUE_W - 1));
   assign sts.quot_zero  = (quot_ff == '0);
   assign sts.count_zero = (count_ff == '0);
   assign sts.out_free   = !valid_ff || !rsp_stall;

   assign rsp_valid    = valid_ff;
   assign rsp_digit    = digit_ff;
   assign rsp_last     = last_ff;
   assign rsp_bad_base = bad_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_DIGITS))
      else $error("digit count beyond stack depth");

   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !sts.count_zero)
      else $error("pop from empty stack");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit || cmd.emit_error) |-> sts.out_free)
      else $error("output register loaded while holding a stalled transfer");

   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (rem_ff < base_ff))
      else $error("remainder not below base after division step");

endmodule

### design/radix_conversion_digit_stack.sv
// Radix conversion digit stack, top level. Instantiates rcds_ctrl and rcds_dpath.
// The first digit comes out after all D divisions, D = digits of the result (1 to 31);
//   each division runs in the bit-serial divider and is followed by a push.
// One item at a time: a new request is taken only after the last digit is emitted
//   (a stalled output holds this off); a bad base gives a single error result.
// Reset: synchronous, active high; clears the controller and output valid.
module radix_conversion_digit_stack
   import rcds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [BASE_W-1:0]  req_base,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DIGIT_W-1:0] rsp_digit,
   output logic               rsp_last,
   output logic               rsp_bad_base
);

   rcds_cmd_type cmd;
   rcds_sts_type sts;

   rcds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcds_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .req_base     (req_base),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_digit    (rsp_digit),
      .rsp_last     (rsp_last),
      .rsp_bad_base (rsp_bad_base)
   );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for radix_conversion_digit_stack: random and directed numbers are
// converted, and every digit transfer is checked against a predictor.
// Depends on rcds_pkg and the block's top level only.
module tb
   import rcds_pkg::*;
();

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
      int unsigned        gap;
   } number_item_type;

   typedef struct {
      logic [DIGIT_W-1:0] digit;
      logic               last;
      logic               bad_base;
   } digit_item_type;

   localparam int HOLD_CYCLES = 3000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value = '0;
   logic [BASE_W-1:0]  req_base = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [DIGIT_W-1:0] rsp_digit;
   logic               rsp_last;
   logic               rsp_bad_base;
   logic               hold_long = 1'b0;

   number_item_type number_queue[$];
   digit_item_type  expected_digits[$];
   int unsigned  wait_left = 0;
   int unsigned  stall_left = 0;
   int unsigned  accepted_count = 0;
   int unsigned  digit_count = 0;
   int unsigned  bad_base_count = 0;
   int unsigned  longest_run = 0;
   int unsigned  error_count = 0;

   radix_conversion_digit_stack u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_base     (req_base),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_digit    (rsp_digit),
      .rsp_last     (rsp_last),
      .rsp_bad_base (rsp_bad_base)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Divide repeatedly, stack the remainders, then unstack most significant first.
   task automatic convert_to_digits(input logic [VALUE_W-1:0] value,
                                    input logic [BASE_W-1:0] base);
      logic [DIGIT_W-1:0] remainders[$];
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] d;
      if (base < MIN_BASE) begin
         expected_digits.push_back('{digit: '0, last: 1'b1, bad_base: 1'b1});
         bad_base_count++;
      end else begin
         quotient = value;
         do begin
            if (remainders.size() < MAX_DIGITS)
               remainders.push_back(DIGIT_W'(quotient % VALUE_W'(base)));
            quotient = quotient / VALUE_W'(base);
         end while (quotient != 0);
         if (remainders.size() > longest_run)
            longest_run = remainders.size();
         while (remainders.size() > 0) begin
            d = remainders.pop_back();
            expected_digits.push_back('{digit: d, last: remainders.size() == 0,
                                        bad_base: 1'b0});
         end
      end
   endtask

   task automatic add_number(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base);
      int unsigned gap;
      gap = ((number_queue.size() / 20) % 3 == 0) ? 0 : $urandom_range(0, 3);
      number_queue.push_back('{value: value, base: base, gap: gap});
   endtask

   // Sender
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         wait_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            convert_to_digits(req_value, req_base);
            void'(number_queue.pop_front());
            accepted_count++;
            next_valid = 1'b0;
            if (number_queue.size() > 0)
               wait_left = number_queue[0].gap;
         end
         if (!next_valid && number_queue.size() > 0) begin
            if (wait_left > 0) begin
               wait_left--;
            end else begin
               next_valid = 1'b1;
               req_value <= number_queue[0].value;
               req_base  <= number_queue[0].base;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver and checker
   always @(posedge clock) begin
      digit_item_type want;
      logic next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            digit_count++;
            if (expected_digits.size() == 0) begin
               $error("digit transfer with none expected: digit %0d", rsp_digit);
               error_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit !== want.digit) begin
                  $error("digit: expected %0d, got %0d", want.digit, rsp_digit);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  error_count++;
               end
               if (rsp_bad_base !== want.bad_base) begin
                  $error("bad_base: expected %0b, got %0b", want.bad_base, rsp_bad_base);
                  error_count++;
               end
            end
            stall_left = ((digit_count / 40) % 3 == 0) ? 0 : $urandom_range(0, 3);
         end
         if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else begin
            next_stall = hold_long;
         end
         rsp_stall <= next_stall;
      end
   end

   // Long hold-off on the result side so the block backs up into its input
   initial begin
      while (accepted_count < 40) @(posedge clock);
      hold_long <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_long <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("radix_conversion_digit_stack verification failed");
      $finish;
   end

   initial begin
      int unsigned pick;
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0] base;

      // directed: zero value, bad bases, widest and narrowest fields
      add_number('0, 8'd10);
      add_number('0, 8'd2);
      add_number('0, 8'd0);
      add_number('1, 8'd1);
      add_number({VALUE_W{1'b1}}, 8'd0);
      add_number({VALUE_W{1'b1}}, 8'd2);
      add_number({VALUE_W{1'b1}}, 8'd255);
      add_number({VALUE_W{1'b1}}, 8'd16);
      add_number({VALUE_W{1'b1}}, 8'd10);
      add_number(31'd1, 8'd2);
      add_number(31'd1, 8'd255);
      add_number(31'd254, 8'd255);
      add_number(31'd255, 8'd255);
      add_number(31'd65025, 8'd255);
      add_number(31'h4000_0000, 8'd2);
      add_number(31'h2AAA_AAAA, 8'd2);
      add_number(31'h5555_5555, 8'd2);
      add_number(31'd1234567890, 8'd10);
      add_number(31'd2, 8'd3);
      add_number(31'd100, 8'd128);
      add_number(31'd7, 8'd1);

      for (int i = 0; i < 240; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            base = BASE_W'($urandom_range(0, 1));
         else if (pick < 50)
            base = BASE_W'($urandom_range(2, 16));
         else
            base = BASE_W'($urandom_range(2, 255));
         pick = $urandom_range(0, 9);
         if (pick == 0)
            value = '0;
         else if (pick < 4)
            value = VALUE_W'($urandom);
         else
            value = VALUE_W'($urandom) >> $urandom_range(0, 30);
         add_number(value, base);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (number_queue.size() > 0) @(posedge clock);
      while (expected_digits.size() > 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("Converted %0d numbers into %0d digit transfers", accepted_count, digit_count);
      $display("(%0d bad bases, up to %0d digits), with a %0d-cycle result hold-off.",
               bad_base_count, longest_run, HOLD_CYCLES);
      if (error_count == 0)
         $display("radix_conversion_digit_stack verification clean");
      else
         $display("radix_conversion_digit_stack verification failed");
      $finish;
   end

endmodule
